@@ rtl/fqlt_pkg.sv @@
// Shared types and constants of the four-quadrant light tracker.
package fqlt_pkg;

    // Register indexes on the configuration port (paddr bit 2).
    localparam logic REG_POSITION_FLOOR   = 1'b0;
    localparam logic REG_POSITION_CEILING = 1'b1;

    // Widths of the main quantities.
    localparam int SAMPLE_W = 10;
    localparam int ANGLE_W  = 8;
    localparam int BAND_W   = 7;
    localparam int TICK_W   = 7;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [ANGLE_W-1:0]  angle_t;
    typedef logic [BAND_W-1:0]   band_t;
    typedef logic [TICK_W-1:0]   tick_t;

    // Reset values of the state.
    localparam angle_t ANGLE_RESET   = 8'd90;
    localparam band_t  BAND_RESET    = 7'd100;
    localparam tick_t  PERIOD_RESET  = 7'd50;
    localparam angle_t FLOOR_RESET   = 8'd0;
    localparam angle_t CEILING_RESET = 8'd180;
    localparam tick_t  TICK_MAX      = 7'd127;

    // Light level window and fallback values.
    localparam sample_t LEVEL_LOW     = 10'd10;
    localparam sample_t LEVEL_HIGH    = 10'd300;
    localparam band_t   BAND_BASE     = 7'd5;
    localparam tick_t   PERIOD_BASE   = 7'd100;
    localparam band_t   BAND_DEFAULT  = 7'd50;
    localparam tick_t   PERIOD_DEFAULT = 7'd50;

    // (x * 95) / 290 == (x * 19) / 58, done as x * ceil(19 * 2^19 / 58) >> 19.
    // Exact for x below 290.
    localparam logic [17:0] BAND_RECIP   = 18'd171750;
    localparam int          BAND_SHIFT   = 19;
    // (x * 50) / 290 == (x * 5) / 29, done as x * ceil(5 * 2^16 / 29) >> 16.
    localparam logic [13:0] PERIOD_RECIP = 14'd11300;
    localparam int          PERIOD_SHIFT = 16;

endpackage

@@ rtl/four_quadrant_light_tracker_unit.sv @@
// Top level of the four-quadrant light tracker: tick counter, update datapath and APB registers.

// Each sample beat is one millisecond tick with four quadrant light readings, and each tick
// yields exactly one result beat. The unit takes one sample beat per clock cycle; each sample
// passes through the input register and then the result register, and the only thing that slows
// the unit down is result_stall, which holds the result register and then the input register.
// On the tick on which the update interval has run out, the unit averages
// the quadrant pairs, picks a new tolerance and interval from the overall light level, steps
// each axis by one degree when its difference exceeds the tolerance, and clamps both axes to
// the floor and ceiling registers. Register writes take effect at the next update.
module four_quadrant_light_tracker_unit
    import fqlt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Sample channel
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [9:0]  light_top_left,
    input  logic [9:0]  light_top_right,
    input  logic [9:0]  light_bottom_left,
    input  logic [9:0]  light_bottom_right,
    // Result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic        update_done,
    output logic [7:0]  horizontal_position,
    output logic [7:0]  vertical_position,
    output logic [6:0]  tolerance_now,
    output logic [6:0]  interval_now
);

    // Configuration registers.
    angle_t floor_reg;
    angle_t ceiling_reg;
    logic   cfg_write;

    // Input register.
    logic    s1_valid_reg;
    sample_t tl_reg;
    sample_t tr_reg;
    sample_t bl_reg;
    sample_t br_reg;

    // Tracker state.
    angle_t horiz_reg;
    angle_t vert_reg;
    band_t  band_reg;
    tick_t  period_reg;
    tick_t  ticks_reg;

    // Result register.
    logic   out_valid_reg;
    logic   out_done_reg;
    angle_t out_horiz_reg;
    angle_t out_vert_reg;
    band_t  out_band_reg;
    tick_t  out_period_reg;

    // Datapath signals.
    logic                advance;
    tick_t               ticks_inc;
    logic                update;
    logic [SAMPLE_W:0]   sum_top;
    logic [SAMPLE_W:0]   sum_bot;
    logic [SAMPLE_W:0]   sum_left;
    logic [SAMPLE_W:0]   sum_right;
    sample_t             avg_top;
    sample_t             avg_bot;
    sample_t             avg_left;
    sample_t             avg_right;
    logic [SAMPLE_W:0]   sum_level;
    sample_t             level;
    logic                in_window;
    logic [8:0]          level_off;
    logic [26:0]         band_prod;
    logic [22:0]         period_prod;
    band_t               band_quot;
    logic [5:0]          period_quot;
    band_t               band_next;
    tick_t               period_next;
    tick_t               ticks_next;
    angle_t              horiz_next;
    angle_t              vert_next;
    angle_t              horiz_step;
    angle_t              vert_step;
    logic signed [SAMPLE_W:0] diff_v;
    logic signed [SAMPLE_W:0] diff_h;

    // Moves one axis by the sign of its difference when the magnitude beats the band,
    // then clamps it; the floor is tested before the ceiling.
    function automatic angle_t step_axis(input angle_t pos, input logic signed [10:0] diff,
                                         input band_t band, input angle_t lo, input angle_t hi);
        logic [10:0]        mag;
        logic signed [9:0]  moved;
        logic signed [9:0]  lo_s;
        logic signed [9:0]  hi_s;
        angle_t             res;
        mag   = diff[10] ? 11'(-diff) : 11'(diff);
        moved = $signed({2'b00, pos});
        if (mag > {4'b0000, band})
        begin
            moved = diff[10] ? moved - 10'sd1 : moved + 10'sd1;
        end
        lo_s = $signed({2'b00, lo});
        hi_s = $signed({2'b00, hi});
        if (moved < lo_s)
        begin
            res = lo;
        end
        else if (moved > hi_s)
        begin
            res = hi;
        end
        else
        begin
            res = moved[7:0];
        end
        return res;
    endfunction

    // APB port: always ready, writes on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_POSITION_FLOOR:   prdata = {24'd0, floor_reg};
            REG_POSITION_CEILING: prdata = {24'd0, ceiling_reg};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= FLOOR_RESET;
            ceiling_reg <= CEILING_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_POSITION_FLOOR:   floor_reg   <= pwdata[7:0];
                REG_POSITION_CEILING: ceiling_reg <= pwdata[7:0];
                default:              floor_reg   <= floor_reg;
            endcase
        end
    end

    // Flow control: the result register moves when it is empty or being taken.
    assign advance      = !out_valid_reg || !result_stall;
    assign sample_stall = s1_valid_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            s1_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            tl_reg <= light_top_left;
            tr_reg <= light_top_right;
            bl_reg <= light_bottom_left;
            br_reg <= light_bottom_right;
        end
    end

    // Tick counter: count first, saturating, then test against the period.
    assign ticks_inc = (ticks_reg < TICK_MAX) ? ticks_reg + 7'd1 : ticks_reg;
    assign update    = ticks_inc >= period_reg;

    // Pair averages, differences and overall level.
    assign sum_top   = {1'b0, tl_reg} + {1'b0, tr_reg};
    assign sum_bot   = {1'b0, bl_reg} + {1'b0, br_reg};
    assign sum_left  = {1'b0, tl_reg} + {1'b0, bl_reg};
    assign sum_right = {1'b0, tr_reg} + {1'b0, br_reg};
    assign avg_top   = sum_top[SAMPLE_W:1];
    assign avg_bot   = sum_bot[SAMPLE_W:1];
    assign avg_left  = sum_left[SAMPLE_W:1];
    assign avg_right = sum_right[SAMPLE_W:1];
    assign diff_v    = $signed({1'b0, avg_top}) - $signed({1'b0, avg_bot});
    assign diff_h    = $signed({1'b0, avg_left}) - $signed({1'b0, avg_right});
    assign sum_level = {1'b0, avg_top} + {1'b0, avg_bot};
    assign level     = sum_level[SAMPLE_W:1];

    // Tolerance and interval from the level, divisions by reciprocal multiplication.
    assign in_window   = (level > LEVEL_LOW) && (level < LEVEL_HIGH);
    assign level_off   = 9'(level - LEVEL_LOW);
    assign band_prod   = 27'(level_off * BAND_RECIP);
    assign period_prod = 23'(level_off * PERIOD_RECIP);
    assign band_quot   = band_prod[BAND_SHIFT+6:BAND_SHIFT];
    assign period_quot = period_prod[PERIOD_SHIFT+5:PERIOD_SHIFT];
    assign band_next   = in_window ? BAND_BASE + band_quot : BAND_DEFAULT;
    assign period_next = in_window ? PERIOD_BASE - {1'b0, period_quot} : PERIOD_DEFAULT;

    // Axis steps use the new tolerance.
    assign horiz_step = step_axis(horiz_reg, diff_h, band_next, floor_reg, ceiling_reg);
    assign vert_step  = step_axis(vert_reg, diff_v, band_next, floor_reg, ceiling_reg);

    // Next state of the tracker for the tick now in the input register.
    always_comb
    begin
        if (update)
        begin
            ticks_next = '0;
            horiz_next = horiz_step;
            vert_next  = vert_step;
        end
        else
        begin
            ticks_next = ticks_inc;
            horiz_next = horiz_reg;
            vert_next  = vert_reg;
        end
    end

    // Tracker state moves together with the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horiz_reg  <= ANGLE_RESET;
            vert_reg   <= ANGLE_RESET;
            band_reg   <= BAND_RESET;
            period_reg <= PERIOD_RESET;
            ticks_reg  <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            horiz_reg <= horiz_next;
            vert_reg  <= vert_next;
            ticks_reg <= ticks_next;
            if (update)
            begin
                band_reg   <= band_next;
                period_reg <= period_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            out_done_reg   <= update;
            out_horiz_reg  <= horiz_next;
            out_vert_reg   <= vert_next;
            out_band_reg   <= update ? band_next : band_reg;
            out_period_reg <= update ? period_next : period_reg;
        end
    end

    assign result_valid        = out_valid_reg;
    assign update_done         = out_done_reg;
    assign horizontal_position = out_horiz_reg;
    assign vertical_position   = out_vert_reg;
    assign tolerance_now       = out_band_reg;
    assign interval_now        = out_period_reg;

`ifndef ASSERT_OFF
    // The counter is always cleared before it can reach the period.
    a_ticks_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        ticks_reg < period_reg)
        else $error("tick counter reached the update period");

    // Tolerance and interval stay inside their mapped ranges.
    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        band_reg >= BAND_BASE && band_reg <= BAND_RESET
        && period_reg >= PERIOD_DEFAULT && period_reg <= PERIOD_BASE)
        else $error("tolerance or interval out of range");

    // A tick that updates clears the counter.
    a_update_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && update) |=> ticks_reg == '0)
        else $error("update did not clear the tick counter");

    // A held tick in the input register is not dropped while the result is stalled.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && result_stall) |=> s1_valid_reg && out_valid_reg)
        else $error("beat lost under result stall");
`endif

endmodule
